>>> rtl/core/sgr_pkg.sv
// Package for the scaled glyph rasterizer: beat structs, register indexes,
// glyph ROM and dot-column expansion. No dependencies.
`default_nettype none

package sgr_pkg;

    localparam int COORD_BITS  = 13;
    localparam int MAX_SCALE   = 8;
    localparam int GLYPH_COUNT = 11;
    localparam int ADDR_BITS   = 26;
    localparam int MASK_BITS   = 8 * MAX_SCALE;
    localparam int COLOR_BITS  = 32;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_STRIDE  = 2'd2;

    localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [COORD_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [COORD_BITS-1:0] LINE_STRIDE_RST  = 13'd640;

    typedef struct packed {
        logic [7:0]            char_code;
        logic                  first_of_text;
        logic [COORD_BITS-1:0] text_x;
        logic [COORD_BITS-1:0] text_y;
        logic [3:0]            scale;
        logic [COLOR_BITS-1:0] text_color;
    } sgr_in_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [MASK_BITS-1:0]  pixel_mask;
        logic [COLOR_BITS-1:0] write_color;
        logic                  last_row;
    } sgr_out_t;

    // 8x8 glyphs, top row in the high byte, leftmost dot in the MSB.
    // Codes outside the font draw blank.
    function automatic logic [7:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
        logic [63:0] g;
        unique case (code)
            8'h42:   g = 64'h7C42427C42427C00; // B
            8'h45:   g = 64'h7E40407C40407E00; // E
            8'h46:   g = 64'h7E40407C40404000; // F
            8'h49:   g = 64'h7E18181818187E00; // I
            8'h4E:   g = 64'h4262524A46424200; // N
            8'h4F:   g = 64'h3C42424242423C00; // O
            8'h53:   g = 64'h3E40403C02027C00; // S
            8'h54:   g = 64'h7E18181818181800; // T
            8'h55:   g = 64'h4242424242423C00; // U
            8'h59:   g = 64'h4242241818181800; // Y
            default: g = '0;                    // space and unknown codes
        endcase
        return g[{~row, 3'b000} +: 8];
    endfunction

    // Clamp scale into 1..MAX_SCALE
    function automatic logic [3:0] scale_clamp(input logic [3:0] sc);
        logic [3:0] r;
        if (sc == 4'd0) begin
            r = 4'd1;
        end else if (sc > 4'(MAX_SCALE)) begin
            r = 4'(MAX_SCALE);
        end else begin
            r = sc;
        end
        return r;
    endfunction

    // Replicate each glyph dot sc times horizontally; bits at 8*sc and up stay 0
    function automatic logic [MASK_BITS-1:0] glyph_expand(input logic [7:0] bits,
                                                         input logic [3:0] sc);
        logic [MASK_BITS-1:0] m;
        m = '0;
        for (int s = 1; s <= MAX_SCALE; s++) begin
            if (sc == 4'(s)) begin
                for (int d = 0; d < 8; d++) begin
                    for (int k = 0; k < MAX_SCALE; k++) begin
                        if (k < s) begin
                            m[d*s+k] = bits[7-d];
                        end
                    end
                end
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/scaled_glyph_rasterizer.sv
// Scaled glyph rasterizer top level: sequencer, base address multiplier, row address adder, output register.
// Depends on sgr_pkg.
`default_nettype none

// Channel   Ports                         Beat
// --------  ----------------------------  ------------------------------------------
// input     s_valid / s_ready / s_data    one character (sgr_in_t)
// output    m_valid / m_ready / m_data    one scaled glyph row span (sgr_out_t)
// config    cfg_wr_en / cfg_index / ...   write of frame_width, frame_height, line_stride
//
// A character passes through accept, base address multiply, row beats and cursor
// update. The row beats cover the R rows inside the frame (at most 8*scale, so up
// to 64), one row beat per cycle from the output register; output stalls hold the
// row loop, which runs on a single adder that steps the address by line_stride.
// Reset clears the sequencer and cursor and loads the config registers with their
// defaults; s_ready is high only while the sequencer is idle.

module scaled_glyph_rasterizer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire sgr_pkg::sgr_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output sgr_pkg::sgr_out_t                      m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sgr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [sgr_pkg::COORD_BITS-1:0]    cfg_wdata
);
    import sgr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ROWS = 2'd2;
    localparam logic [1:0] ST_ADV  = 2'd3;

    localparam int CLIP_BITS = $clog2(MASK_BITS) + 1;

    logic [1:0]              state_reg, state_next;
    logic [COORD_BITS-1:0]   fw_reg, fh_reg, stride_reg;
    logic [COORD_BITS-1:0]   cursor_reg, cursor_next;
    logic [7:0]              code_reg, code_next;
    logic [COLOR_BITS-1:0]   color_reg, color_next;
    logic [3:0]              scale_reg, scale_next;
    logic [COORD_BITS:0]     y_reg, y_next;          // text_y + row, one spare bit
    logic [2:0]              sub_reg, sub_next;      // repeat count within a dot row
    logic [2:0]              grow_reg, grow_next;    // glyph row
    logic [ADDR_BITS-1:0]    addr_reg, addr_next;
    logic [MASK_BITS-1:0]    clip_reg, clip_next;
    logic                    m_valid_reg, m_valid_next;
    sgr_out_t                m_data_reg, m_data_next;

    logic                    s_fire, out_free, row_last;
    logic [COORD_BITS:0]     y_inc;
    logic [3:0]              scale_m1;
    logic [2*COORD_BITS-1:0] base_prod;
    logic [COORD_BITS:0]     clip_diff;
    logic [CLIP_BITS-1:0]    clip_lim;
    logic [COORD_BITS:0]     cursor_sum;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign y_inc    = y_reg + (COORD_BITS+1)'(1);
    assign scale_m1 = scale_reg - 4'd1;
    // Final row: last scaled row of the glyph, or the next line falls off the frame
    assign row_last = ((grow_reg == 3'd7) && ({1'b0, sub_reg} == scale_m1))
                   || (y_inc >= {1'b0, fh_reg});

    assign base_prod  = y_reg[COORD_BITS-1:0] * stride_reg;
    assign clip_diff  = {1'b0, fw_reg} - {1'b0, cursor_reg};
    // cursor + 9*scale, saturating
    assign cursor_sum = {1'b0, cursor_reg} + (COORD_BITS+1)'({scale_reg, 3'b000})
                      + (COORD_BITS+1)'(scale_reg);

    always_comb begin
        // number of visible columns from the cursor, capped at the mask width
        if (fw_reg <= cursor_reg) begin
            clip_lim = '0;
        end else if (clip_diff >= (COORD_BITS+1)'(MASK_BITS)) begin
            clip_lim = CLIP_BITS'(MASK_BITS);
        end else begin
            clip_lim = clip_diff[CLIP_BITS-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        code_next    = code_reg;
        color_next   = color_reg;
        scale_next   = scale_reg;
        y_next       = y_reg;
        sub_next     = sub_reg;
        grow_next    = grow_reg;
        addr_next    = addr_reg;
        clip_next    = clip_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    code_next  = s_data.char_code;
                    color_next = s_data.text_color;
                    scale_next = scale_clamp(s_data.scale);
                    y_next     = {1'b0, s_data.text_y};
                    if (s_data.first_of_text) begin
                        cursor_next = s_data.text_x;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                addr_next = base_prod[ADDR_BITS-1:0] + ADDR_BITS'(cursor_reg);
                for (int c = 0; c < MASK_BITS; c++) begin
                    clip_next[c] = (CLIP_BITS'(c) < clip_lim);
                end
                sub_next  = '0;
                grow_next = '0;
                if (y_reg >= {1'b0, fh_reg}) begin
                    state_next = ST_ADV;            // whole glyph below the frame
                end else begin
                    state_next = ST_ROWS;
                end
            end
            ST_ROWS: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.pixel_address = addr_reg;
                    m_data_next.pixel_mask    =
                        glyph_expand(glyph_row(code_reg, grow_reg), scale_reg) & clip_reg;
                    m_data_next.write_color   = color_reg;
                    m_data_next.last_row      = row_last;
                    addr_next = addr_reg + ADDR_BITS'(stride_reg);
                    y_next    = y_inc;
                    if ({1'b0, sub_reg} == scale_m1) begin
                        sub_next  = '0;
                        grow_next = grow_reg + 3'd1;
                    end else begin
                        sub_next = sub_reg + 3'd1;
                    end
                    if (row_last) begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_ADV: begin
                if (cursor_sum[COORD_BITS]) begin
                    cursor_next = '1;
                end else begin
                    cursor_next = cursor_sum[COORD_BITS-1:0];
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
            fw_reg      <= FRAME_WIDTH_RST;
            fh_reg      <= FRAME_HEIGHT_RST;
            stride_reg  <= LINE_STRIDE_RST;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg     <= cfg_wdata;
                    CFG_FRAME_HEIGHT: fh_reg     <= cfg_wdata;
                    CFG_LINE_STRIDE:  stride_reg <= cfg_wdata;
                    default: ;                       // unused index: ignored
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        code_reg   <= code_next;
        color_reg  <= color_next;
        scale_reg  <= scale_next;
        y_reg      <= y_next;
        sub_reg    <= sub_next;
        grow_reg   <= grow_next;
        addr_reg   <= addr_next;
        clip_reg   <= clip_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/sgr_checker.sv
// Port-level checker for scaled_glyph_rasterizer, with its bind statement.
// Depends on sgr_pkg.
`default_nettype none

module sgr_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire sgr_pkg::sgr_in_t                  s_data,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire sgr_pkg::sgr_out_t                 m_data,
    input wire logic                              cfg_wr_en,
    input wire logic [sgr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input wire logic [sgr_pkg::COORD_BITS-1:0]    cfg_wdata
);
    import sgr_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_data, cfg_wr_en, cfg_index, cfg_wdata};

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed under stall");

    // a character keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind scaled_glyph_rasterizer sgr_checker u_sgr_checker (.*);

`default_nettype wire
